@@ hw/rtl/mhp_pkg.sv @@
// Shared types and codes for the binary max-heap pop block.
// No dependencies; the top level and the checker refer to this package by scoped names.
`default_nettype none

package mhp_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_POP    = 1'b1
  } mhp_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } mhp_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_LOAD_CUR,
    ST_LEVEL,
    ST_LEFT,
    ST_RIGHT,
    ST_RESP
  } mhp_state_e;

  typedef struct packed {
    mhp_cmd_e                   command;
    logic signed [ValueW-1:0]   value;
  } mhp_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0]   popped_value;
    mhp_status_e                status;
    logic        [CountW-1:0]   count_after;
  } mhp_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/max_heap_pop_sift_down_top.sv @@
// Max-heap pop top level: sequencer, shared compare unit, output register; uses mhp_pkg, mhp_ram.
// Append and empty pop go straight to the result. A successful pop reads the root, then the last
// element, then sinks it, moving the larger child up at each level, until it reaches a childless
// slot or a compare stops it; the children are read in turn through the one RAM read port.
// One item at a time; the next is accepted once its result has entered the output register.
// Reset (async, active low) clears the element count and control; heap RAM is not cleared.
`default_nettype none

module max_heap_pop_sift_down_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire mhp_pkg::mhp_in_t in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output mhp_pkg::mhp_out_t     out_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = AW + 2;
  localparam int unsigned VW   = mhp_pkg::ValueW;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  mhp_pkg::mhp_state_e state_q, state_d;

  logic [CW-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [AW-1:0]          best_idx_q, best_idx_d;
  logic                   best_child_q, best_child_d;
  logic                   rc_ok_q, rc_ok_d;
  logic signed [VW-1:0]   cur_q, cur_d;
  logic signed [VW-1:0]   bestv_q, bestv_d;
  logic signed [VW-1:0]   popped_q, popped_d;
  mhp_pkg::mhp_status_e   status_q, status_d;
  logic                   out_vld_q, out_vld_d;
  mhp_pkg::mhp_out_t      out_q, out_d;

  logic                   in_fire;
  logic                   resp_load;
  logic [IW-1:0]          lc, rc, cnt_ext;
  logic                   lc_in, rc_in;

  // RAM port controls
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VW-1:0]          ram_wdata, ram_rdata;

  // Shared compare unit
  logic signed [VW-1:0]   cmp_a, cmp_b;
  logic                   cmp_gt;

  assign in_ready_o = (state_q == mhp_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign resp_load  = (state_q == mhp_pkg::ST_RESP) && (!out_vld_q || out_ready_i);

  // Child indexes of the current hole
  assign lc      = {1'b0, pos_q, 1'b1};
  assign rc      = lc + IW'(1);
  assign cnt_ext = IW'(cnt_q);
  assign lc_in   = lc < cnt_ext;
  assign rc_in   = rc < cnt_ext;

  assign cmp_a  = $signed(ram_rdata);
  assign cmp_b  = (state_q == mhp_pkg::ST_LEFT) ? cur_q : bestv_q;
  assign cmp_gt = cmp_a > cmp_b;

  mhp_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mhp_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.command == mhp_pkg::CMD_POP && cnt_q != '0) begin
            state_d = mhp_pkg::ST_RD_LAST;
          end else begin
            state_d = mhp_pkg::ST_RESP;
          end
        end
      end
      mhp_pkg::ST_RD_LAST:  state_d = mhp_pkg::ST_LOAD_CUR;
      mhp_pkg::ST_LOAD_CUR: state_d = mhp_pkg::ST_LEVEL;
      mhp_pkg::ST_LEVEL:    state_d = lc_in ? mhp_pkg::ST_LEFT : mhp_pkg::ST_RESP;
      mhp_pkg::ST_LEFT:     state_d = mhp_pkg::ST_RIGHT;
      mhp_pkg::ST_RIGHT: begin
        if (rc_ok_q && cmp_gt) begin
          state_d = mhp_pkg::ST_LEVEL;
        end else if (best_child_q) begin
          state_d = mhp_pkg::ST_LEVEL;
        end else begin
          state_d = mhp_pkg::ST_RESP;
        end
      end
      mhp_pkg::ST_RESP: begin
        if (resp_load) begin
          state_d = mhp_pkg::ST_IDLE;
        end
      end
      default: state_d = mhp_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    best_idx_d   = best_idx_q;
    best_child_d = best_child_q;
    rc_ok_d      = rc_ok_q;
    cur_d        = cur_q;
    bestv_d      = bestv_q;
    popped_d     = popped_q;
    status_d     = status_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = cur_q;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_q)
      mhp_pkg::ST_IDLE: begin
        if (in_fire) begin
          popped_d = '0;
          status_d = mhp_pkg::STATUS_OK;
          if (in_i.command == mhp_pkg::CMD_APPEND) begin
            if (cnt_q == CapCnt) begin
              status_d = mhp_pkg::STATUS_OVERFLOW;
            end else begin
              // Append straight into the next free slot
              ram_we    = 1'b1;
              ram_waddr = cnt_q[AW-1:0];
              ram_wdata = in_i.value;
              cnt_d     = cnt_q + CW'(1);
            end
          end else if (cnt_q == '0) begin
            status_d = mhp_pkg::STATUS_UNDERFLOW;
          end else begin
            // Fetch the root and shrink the count
            ram_re    = 1'b1;
            ram_raddr = '0;
            cnt_d     = cnt_q - CW'(1);
          end
        end
      end
      mhp_pkg::ST_RD_LAST: begin
        // Root arrives; fetch the last element (index equals the new count)
        popped_d  = $signed(ram_rdata);
        ram_re    = 1'b1;
        ram_raddr = cnt_q[AW-1:0];
      end
      mhp_pkg::ST_LOAD_CUR: begin
        cur_d = $signed(ram_rdata);
        pos_d = '0;
      end
      mhp_pkg::ST_LEVEL: begin
        if (lc_in) begin
          ram_re    = 1'b1;
          ram_raddr = lc[AW-1:0];
          rc_ok_d   = rc_in;
        end else begin
          // Leaf reached: drop the moving element into the hole
          ram_we = 1'b1;
        end
      end
      mhp_pkg::ST_LEFT: begin
        // Left child against the moving element
        if (cmp_gt) begin
          bestv_d      = $signed(ram_rdata);
          best_idx_d   = lc[AW-1:0];
          best_child_d = 1'b1;
        end else begin
          bestv_d      = cur_q;
          best_child_d = 1'b0;
        end
        if (rc_in) begin
          ram_re    = 1'b1;
          ram_raddr = rc[AW-1:0];
        end
      end
      mhp_pkg::ST_RIGHT: begin
        // Right child against the best so far; ties keep the left
        ram_we = 1'b1;
        if (rc_ok_q && cmp_gt) begin
          ram_wdata = ram_rdata;
          pos_d     = rc[AW-1:0];
        end else if (best_child_q) begin
          ram_wdata = bestv_q;
          pos_d     = best_idx_q;
        end else begin
          ram_wdata = cur_q;
        end
      end
      mhp_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    if (resp_load) begin
      out_d.popped_value = popped_q;
      out_d.status       = status_q;
      out_d.count_after  = mhp_pkg::CountW'(cnt_q);
      out_vld_d          = 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mhp_pkg::ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    best_idx_q   <= best_idx_d;
    best_child_q <= best_child_d;
    rc_ok_q      <= rc_ok_d;
    cur_q        <= cur_d;
    bestv_q      <= bestv_d;
    popped_q     <= popped_d;
    status_q     <= status_d;
    out_q        <= out_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/mhp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mhp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mhp_checker.sv @@
// Port-level assertions for the max-heap pop block, bound to its top level.
// Depends on mhp_pkg and max_heap_pop_sift_down_top.
`default_nettype none

module mhp_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire mhp_pkg::mhp_out_t out_o
);

  localparam logic [mhp_pkg::CountW-1:0] FullCnt = mhp_pkg::CountW'(CAPACITY);

  // One transaction at a time: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous transaction in flight");

  // Underflow leaves an empty store and returns zero
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == mhp_pkg::STATUS_UNDERFLOW |->
      out_o.popped_value == '0 && out_o.count_after == '0)
    else $error("underflow result with nonzero value or count");

  // Overflow only on a full store and returns zero
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == mhp_pkg::STATUS_OVERFLOW |->
      out_o.popped_value == '0 && out_o.count_after == FullCnt)
    else $error("overflow result with nonzero value or wrong count");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed or dropped while stalled");

endmodule

bind max_heap_pop_sift_down_top mhp_checker #(
  .CAPACITY(CAPACITY)
) u_mhp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_o      (out_o)
);

`default_nettype wire
